// File: design/gzht_pkg.sv
// Package for the gzip header and trailer parser: codes, result record, routing.
package gzht_pkg;

    // Parse phases
    localparam logic [4:0] P_IDLE  = 5'd0;
    localparam logic [4:0] P_ID1   = 5'd1;
    localparam logic [4:0] P_ID2   = 5'd2;
    localparam logic [4:0] P_CM    = 5'd3;
    localparam logic [4:0] P_FLG   = 5'd4;
    localparam logic [4:0] P_MT0   = 5'd5;
    localparam logic [4:0] P_MT1   = 5'd6;
    localparam logic [4:0] P_MT2   = 5'd7;
    localparam logic [4:0] P_MT3   = 5'd8;
    localparam logic [4:0] P_XFL   = 5'd9;
    localparam logic [4:0] P_OS    = 5'd10;
    localparam logic [4:0] P_XLEN0 = 5'd11;
    localparam logic [4:0] P_XLEN1 = 5'd12;
    localparam logic [4:0] P_XSKIP = 5'd13;
    localparam logic [4:0] P_NAME  = 5'd14;
    localparam logic [4:0] P_CMT   = 5'd15;
    localparam logic [4:0] P_HCRC0 = 5'd16;
    localparam logic [4:0] P_HCRC1 = 5'd17;
    localparam logic [4:0] P_BODY  = 5'd18;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_CM    = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;

    // Result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_TRAILER = 1'b1;

    // Header constants
    localparam logic [7:0] ID1_BYTE   = 8'h1F;
    localparam logic [7:0] ID2_BYTE   = 8'h8B;
    localparam logic [7:0] CM_DEFLATE = 8'h08;
    localparam int         FLG_FHCRC  = 1;
    localparam int         FLG_FEXTRA = 2;
    localparam int         FLG_FNAME  = 3;
    localparam int         FLG_FCMT   = 4;
    localparam logic [31:0] MIN_STREAM = 32'd18;

    // Optional-field stages for routing
    localparam logic [2:0] RT_EXTRA = 3'd0;
    localparam logic [2:0] RT_NAME  = 3'd1;
    localparam logic [2:0] RT_CMT   = 3'd2;
    localparam logic [2:0] RT_HCRC  = 3'd3;
    localparam logic [2:0] RT_DONE  = 3'd4;

    // One result word
    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [7:0]  flag_bits;
        logic [31:0] mtime_or_crc;
        logic [7:0]  extra_flag_byte;
        logic [7:0]  os_code;
        logic [15:0] extra_length;
        logic [15:0] name_length;
        logic [15:0] comment_length;
        logic [31:0] length_or_size;
        logic [31:0] stream_length;
        logic        final_res;
    } t_result;

    // Next phase after optional-field stage s, given the FLG byte
    function automatic logic [4:0] route(input logic [7:0] flg, input logic [2:0] s);
        logic [4:0] p;
        p = P_BODY;
        if (s <= RT_HCRC && flg[FLG_FHCRC]) p = P_HCRC0;
        if (s <= RT_CMT && flg[FLG_FCMT]) p = P_CMT;
        if (s <= RT_NAME && flg[FLG_FNAME]) p = P_NAME;
        if (s <= RT_EXTRA && flg[FLG_FEXTRA]) p = P_XLEN0;
        return p;
    endfunction

endpackage

// File: design/gzip_header_trailer_parser.sv
// Top level of the gzip header and trailer parser: byte parser and result queue.
//
// Usage: bytes of a gzip stream arrive on the input channel (i_valid, o_ready,
// i_data_byte, i_first_byte, i_last_byte), one byte per word. i_first_byte
// restarts the parse; bytes outside a stream are dropped silently. Result
// words leave on the output channel (o_valid, i_ready and the o_ result
// fields): a header word when the header completes or fails, and a trailer
// word on the last byte of the stream.
// The result words of an accepted byte are registered into the result queue.
// Throughput: one byte per cycle while o_ready is high. The parser state updates in the accept
// cycle and results go into a three-word queue; o_ready is high while the
// queue holds at most one word, so a byte that yields two results (header
// and trailer on the same byte) drops o_ready until a word leaves the queue.
// When the receiver stalls, the queue fills and o_ready drops; nothing is
// lost. Reset (i_rst_n low, synchronous) empties the queue and returns the
// parser to idle, waiting for a first byte.
module gzip_header_trailer_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [2:0]  o_status,
    output logic [7:0]  o_flag_bits,
    output logic [31:0] o_mtime_or_crc,
    output logic [7:0]  o_extra_flag_byte,
    output logic [7:0]  o_os_code,
    output logic [15:0] o_extra_length,
    output logic [15:0] o_name_length,
    output logic [15:0] o_comment_length,
    output logic [31:0] o_length_or_size,
    output logic [31:0] o_stream_length,
    output logic        o_final_res
);

    // Parser state
    logic [4:0]  r_phase,    n_phase,    c_phase;
    logic [31:0] r_total,    n_total,    c_total;
    logic [7:0]  r_flags,    n_flags,    c_flags;
    logic [31:0] r_mtime,    n_mtime,    c_mtime;
    logic [7:0]  r_xfl,      n_xfl,      c_xfl;
    logic [7:0]  r_os,       n_os,       c_os;
    logic [15:0] r_xlen,     n_xlen,     c_xlen;
    logic [15:0] r_skip,     n_skip,     c_skip;
    logic [15:0] r_name,     n_name,     c_name;
    logic [15:0] r_cmt,      n_cmt,      c_cmt;
    logic [31:0] r_hdr,      n_hdr,      c_hdr;
    logic [63:0] r_tail,     n_tail,     c_tail;

    // Result queue
    gzht_pkg::t_result r_q [3];
    gzht_pkg::t_result n_q [3];
    logic [1:0]        r_count, n_count, cnt_pop;

    logic              accept, pop;
    logic [2:0]        err;
    logic [1:0]        n_res;
    gzht_pkg::t_result rec, res0, res1;

    assign o_ready = (r_count <= 2'd1);
    assign accept  = i_valid && o_ready;
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;

    // Byte parse: state update and results for the accepted byte
    always_comb begin
        // a first byte starts from cleared captures
        if (i_first_byte) begin
            c_phase = gzht_pkg::P_ID1;
            c_total = '0; c_flags = '0; c_mtime = '0; c_xfl = '0; c_os = '0;
            c_xlen = '0; c_skip = '0; c_name = '0; c_cmt = '0; c_hdr = '0;
            c_tail = '0;
        end else begin
            c_phase = r_phase;
            c_total = r_total; c_flags = r_flags; c_mtime = r_mtime; c_xfl = r_xfl;
            c_os = r_os; c_xlen = r_xlen; c_skip = r_skip; c_name = r_name;
            c_cmt = r_cmt; c_hdr = r_hdr; c_tail = r_tail;
        end

        n_phase = r_phase; n_total = r_total; n_flags = r_flags; n_mtime = r_mtime;
        n_xfl = r_xfl; n_os = r_os; n_xlen = r_xlen; n_skip = r_skip; n_name = r_name;
        n_cmt = r_cmt; n_hdr = r_hdr; n_tail = r_tail;
        err   = gzht_pkg::ST_OK;
        n_res = 2'd0;
        rec   = '0;
        res0  = '0;
        res1  = '0;

        if (accept && c_phase != gzht_pkg::P_IDLE && c_phase <= gzht_pkg::P_BODY) begin
            n_phase = c_phase; n_flags = c_flags; n_mtime = c_mtime; n_xfl = c_xfl;
            n_os = c_os; n_xlen = c_xlen; n_skip = c_skip; n_name = c_name; n_cmt = c_cmt;
            n_total = (c_total != '1) ? c_total + 32'd1 : c_total;
            n_hdr   = (c_phase != gzht_pkg::P_BODY && c_hdr != '1) ? c_hdr + 32'd1 : c_hdr;
            n_tail  = {i_data_byte, c_tail[63:8]};

            case (c_phase)
                gzht_pkg::P_ID1: begin
                    if (i_data_byte != gzht_pkg::ID1_BYTE) err = gzht_pkg::ST_BAD_MAGIC;
                    else n_phase = gzht_pkg::P_ID2;
                end
                gzht_pkg::P_ID2: begin
                    if (i_data_byte != gzht_pkg::ID2_BYTE) err = gzht_pkg::ST_BAD_MAGIC;
                    else n_phase = gzht_pkg::P_CM;
                end
                gzht_pkg::P_CM: begin
                    if (i_data_byte != gzht_pkg::CM_DEFLATE) err = gzht_pkg::ST_BAD_CM;
                    else n_phase = gzht_pkg::P_FLG;
                end
                gzht_pkg::P_FLG: begin
                    n_flags = i_data_byte;
                    n_phase = gzht_pkg::P_MT0;
                end
                gzht_pkg::P_MT0: begin
                    n_mtime = c_mtime | {24'd0, i_data_byte};
                    n_phase = gzht_pkg::P_MT1;
                end
                gzht_pkg::P_MT1: begin
                    n_mtime = c_mtime | {16'd0, i_data_byte, 8'd0};
                    n_phase = gzht_pkg::P_MT2;
                end
                gzht_pkg::P_MT2: begin
                    n_mtime = c_mtime | {8'd0, i_data_byte, 16'd0};
                    n_phase = gzht_pkg::P_MT3;
                end
                gzht_pkg::P_MT3: begin
                    n_mtime = c_mtime | {i_data_byte, 24'd0};
                    n_phase = gzht_pkg::P_XFL;
                end
                gzht_pkg::P_XFL: begin
                    n_xfl   = i_data_byte;
                    n_phase = gzht_pkg::P_OS;
                end
                gzht_pkg::P_OS: begin
                    n_os    = i_data_byte;
                    n_phase = gzht_pkg::route(c_flags, gzht_pkg::RT_EXTRA);
                end
                gzht_pkg::P_XLEN0: begin
                    n_xlen  = {8'd0, i_data_byte};
                    n_phase = gzht_pkg::P_XLEN1;
                end
                gzht_pkg::P_XLEN1: begin
                    n_xlen  = c_xlen | {i_data_byte, 8'd0};
                    n_skip  = c_xlen | {i_data_byte, 8'd0};
                    n_phase = ((c_xlen | {i_data_byte, 8'd0}) != 16'd0) ? gzht_pkg::P_XSKIP
                              : gzht_pkg::route(c_flags, gzht_pkg::RT_NAME);
                end
                gzht_pkg::P_XSKIP: begin
                    n_skip = (c_skip != 16'd0) ? c_skip - 16'd1 : c_skip;
                    if (c_skip <= 16'd1) n_phase = gzht_pkg::route(c_flags, gzht_pkg::RT_NAME);
                end
                gzht_pkg::P_NAME: begin
                    if (i_data_byte == 8'd0)
                        n_phase = gzht_pkg::route(c_flags, gzht_pkg::RT_CMT);
                    else if (c_name != '1) n_name = c_name + 16'd1;
                end
                gzht_pkg::P_CMT: begin
                    if (i_data_byte == 8'd0)
                        n_phase = gzht_pkg::route(c_flags, gzht_pkg::RT_HCRC);
                    else if (c_cmt != '1) n_cmt = c_cmt + 16'd1;
                end
                gzht_pkg::P_HCRC0: n_phase = gzht_pkg::P_HCRC1;
                gzht_pkg::P_HCRC1: n_phase = gzht_pkg::route(c_flags, gzht_pkg::RT_DONE);
                default: ;
            endcase

            // common capture fields of a result word
            rec.kind            = gzht_pkg::KIND_HEADER;
            rec.status          = gzht_pkg::ST_OK;
            rec.flag_bits       = n_flags;
            rec.mtime_or_crc    = n_mtime;
            rec.extra_flag_byte = n_xfl;
            rec.os_code         = n_os;
            rec.extra_length    = n_xlen;
            rec.name_length     = n_name;
            rec.comment_length  = n_cmt;
            rec.length_or_size  = n_hdr;
            rec.stream_length   = n_total;
            rec.final_res       = 1'b0;

            if (err != gzht_pkg::ST_OK) begin
                // header failure ends the stream
                res0        = rec;
                res0.status = err;
                n_res       = 2'd1;
                n_phase     = gzht_pkg::P_IDLE;
            end else begin
                res1 = rec;
                if (c_phase != gzht_pkg::P_BODY && n_phase == gzht_pkg::P_BODY) begin
                    res0  = rec;
                    n_res = 2'd1;
                end
                if (i_last_byte) begin
                    if (n_phase == gzht_pkg::P_BODY) begin
                        res1.kind = gzht_pkg::KIND_TRAILER;
                        if (n_total < gzht_pkg::MIN_STREAM) begin
                            res1.status         = gzht_pkg::ST_SHORT;
                            res1.mtime_or_crc   = '0;
                            res1.length_or_size = '0;
                        end else begin
                            res1.mtime_or_crc   = n_tail[31:0];
                            res1.length_or_size = n_tail[63:32];
                        end
                    end else begin
                        res1.status = gzht_pkg::ST_TRUNC;
                    end
                    if (n_res == 2'd0) res0 = res1;
                    n_res   = n_res + 2'd1;
                    n_phase = gzht_pkg::P_IDLE;
                end
            end

            // mark the last result of this byte
            if (n_res == 2'd1) res0.final_res = 1'b1;
            else res1.final_res = 1'b1;
        end else if (accept) begin
            n_res = 2'd0;
        end
    end

    // Queue: shift out at the head, append after the remaining words
    always_comb begin
        cnt_pop = r_count - {1'b0, pop};
        n_q[0]  = pop ? r_q[1] : r_q[0];
        n_q[1]  = pop ? r_q[2] : r_q[1];
        n_q[2]  = r_q[2];
        for (int i = 0; i < 3; i++) begin
            if (n_res != 2'd0 && 2'(i) == cnt_pop) n_q[i] = res0;
            if (n_res == 2'd2 && 2'(i) == cnt_pop + 2'd1) n_q[i] = res1;
        end
        n_count = cnt_pop + n_res;
    end

    // Control and parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= gzht_pkg::P_IDLE;
            r_total <= '0; r_flags <= '0; r_mtime <= '0; r_xfl <= '0; r_os <= '0;
            r_xlen <= '0; r_skip <= '0; r_name <= '0; r_cmt <= '0; r_hdr <= '0;
            r_tail <= '0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
            r_total <= n_total; r_flags <= n_flags; r_mtime <= n_mtime; r_xfl <= n_xfl;
            r_os <= n_os; r_xlen <= n_xlen; r_skip <= n_skip; r_name <= n_name;
            r_cmt <= n_cmt; r_hdr <= n_hdr; r_tail <= n_tail;
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) r_q[i] <= n_q[i];
    end

    // Head of the queue drives the result ports
    assign o_kind            = r_q[0].kind;
    assign o_status          = r_q[0].status;
    assign o_flag_bits       = r_q[0].flag_bits;
    assign o_mtime_or_crc    = r_q[0].mtime_or_crc;
    assign o_extra_flag_byte = r_q[0].extra_flag_byte;
    assign o_os_code         = r_q[0].os_code;
    assign o_extra_length    = r_q[0].extra_length;
    assign o_name_length     = r_q[0].name_length;
    assign o_comment_length  = r_q[0].comment_length;
    assign o_length_or_size  = r_q[0].length_or_size;
    assign o_stream_length   = r_q[0].stream_length;
    assign o_final_res       = r_q[0].final_res;

endmodule

// File: dv/gzip_header_trailer_parser_tb.sv
// Self-checking testbench for the gzip header and trailer parser.
`timescale 1ns / 1ps

module gzip_header_trailer_parser_tb;

    // Tracks the gzip parse of every accepted byte and holds the result words it owes
    class gzip_parse_tracker;
        logic [4:0]  phase;
        logic [31:0] byte_total;
        logic [7:0]  flags;
        logic [31:0] time_word;
        logic [7:0]  xfl;
        logic [7:0]  os;
        logic [15:0] xlen;
        logic [15:0] skip_left;
        logic [15:0] name_cnt;
        logic [15:0] cmt_cnt;
        logic [31:0] header_bytes;
        logic [63:0] tail;
        gzht_pkg::t_result due_results[$];
        int          mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            phase        = gzht_pkg::P_IDLE;
            byte_total   = '0;
            flags        = '0;
            time_word    = '0;
            xfl          = '0;
            os           = '0;
            xlen         = '0;
            skip_left    = '0;
            name_cnt     = '0;
            cmt_cnt      = '0;
            header_bytes = '0;
            tail         = '0;
        endfunction

        // First optional field at or after the given stage, else the body
        function logic [4:0] next_field(input logic [2:0] stage);
            if (stage <= gzht_pkg::RT_EXTRA && flags[gzht_pkg::FLG_FEXTRA])
                return gzht_pkg::P_XLEN0;
            if (stage <= gzht_pkg::RT_NAME && flags[gzht_pkg::FLG_FNAME])
                return gzht_pkg::P_NAME;
            if (stage <= gzht_pkg::RT_CMT && flags[gzht_pkg::FLG_FCMT])
                return gzht_pkg::P_CMT;
            if (stage <= gzht_pkg::RT_HCRC && flags[gzht_pkg::FLG_FHCRC])
                return gzht_pkg::P_HCRC0;
            return gzht_pkg::P_BODY;
        endfunction

        function void add_word(input logic kind, input logic [2:0] status,
                               input logic [31:0] word, input logic [31:0] len);
            gzht_pkg::t_result w;
            w.kind            = kind;
            w.status          = status;
            w.flag_bits       = flags;
            w.mtime_or_crc    = word;
            w.extra_flag_byte = xfl;
            w.os_code         = os;
            w.extra_length    = xlen;
            w.name_length     = name_cnt;
            w.comment_length  = cmt_cnt;
            w.length_or_size  = len;
            w.stream_length   = byte_total;
            w.final_res       = 1'b0;
            due_results.insert(due_results.size(), w);
        endfunction

        // Returns 1 when the byte takes part in a stream, 0 when it is dropped
        function bit note_byte(input logic [7:0] b, input logic first, input logic last);
            logic [4:0] was;
            logic [2:0] fail;
            int         depth_before;
            gzht_pkg::t_result w;
            if (first) begin
                clear();
                phase = gzht_pkg::P_ID1;
            end
            if (phase == gzht_pkg::P_IDLE) return 1'b0;

            was          = phase;
            fail         = gzht_pkg::ST_OK;
            depth_before = due_results.size();
            if (byte_total != 32'hFFFF_FFFF) byte_total++;
            if (was != gzht_pkg::P_BODY && header_bytes != 32'hFFFF_FFFF) header_bytes++;
            tail = {b, tail[63:8]};

            case (was)
                gzht_pkg::P_ID1: begin
                    if (b != gzht_pkg::ID1_BYTE) fail = gzht_pkg::ST_BAD_MAGIC;
                    else phase = gzht_pkg::P_ID2;
                end
                gzht_pkg::P_ID2: begin
                    if (b != gzht_pkg::ID2_BYTE) fail = gzht_pkg::ST_BAD_MAGIC;
                    else phase = gzht_pkg::P_CM;
                end
                gzht_pkg::P_CM: begin
                    if (b != gzht_pkg::CM_DEFLATE) fail = gzht_pkg::ST_BAD_CM;
                    else phase = gzht_pkg::P_FLG;
                end
                gzht_pkg::P_FLG: begin
                    flags = b;
                    phase = gzht_pkg::P_MT0;
                end
                gzht_pkg::P_MT0: begin
                    time_word = time_word | {24'd0, b};
                    phase = gzht_pkg::P_MT1;
                end
                gzht_pkg::P_MT1: begin
                    time_word = time_word | ({24'd0, b} << 8);
                    phase = gzht_pkg::P_MT2;
                end
                gzht_pkg::P_MT2: begin
                    time_word = time_word | ({24'd0, b} << 16);
                    phase = gzht_pkg::P_MT3;
                end
                gzht_pkg::P_MT3: begin
                    time_word = time_word | ({24'd0, b} << 24);
                    phase = gzht_pkg::P_XFL;
                end
                gzht_pkg::P_XFL: begin
                    xfl = b;
                    phase = gzht_pkg::P_OS;
                end
                gzht_pkg::P_OS: begin
                    os = b;
                    phase = next_field(gzht_pkg::RT_EXTRA);
                end
                gzht_pkg::P_XLEN0: begin
                    xlen = {8'd0, b};
                    phase = gzht_pkg::P_XLEN1;
                end
                gzht_pkg::P_XLEN1: begin
                    xlen = xlen | {b, 8'd0};
                    skip_left = xlen;
                    phase = (skip_left != 0) ? gzht_pkg::P_XSKIP
                            : next_field(gzht_pkg::RT_NAME);
                end
                gzht_pkg::P_XSKIP: begin
                    if (skip_left != 0) skip_left--;
                    if (skip_left == 0) phase = next_field(gzht_pkg::RT_NAME);
                end
                gzht_pkg::P_NAME: begin
                    if (b == 8'd0) phase = next_field(gzht_pkg::RT_CMT);
                    else if (name_cnt != 16'hFFFF) name_cnt++;
                end
                gzht_pkg::P_CMT: begin
                    if (b == 8'd0) phase = next_field(gzht_pkg::RT_HCRC);
                    else if (cmt_cnt != 16'hFFFF) cmt_cnt++;
                end
                gzht_pkg::P_HCRC0: phase = gzht_pkg::P_HCRC1;
                gzht_pkg::P_HCRC1: phase = next_field(gzht_pkg::RT_DONE);
                default: ;
            endcase

            if (fail != gzht_pkg::ST_OK) begin
                add_word(gzht_pkg::KIND_HEADER, fail, time_word, header_bytes);
                phase = gzht_pkg::P_IDLE;
            end else begin
                if (was != gzht_pkg::P_BODY && phase == gzht_pkg::P_BODY)
                    add_word(gzht_pkg::KIND_HEADER, gzht_pkg::ST_OK, time_word, header_bytes);
                if (last) begin
                    if (phase != gzht_pkg::P_BODY)
                        add_word(gzht_pkg::KIND_HEADER, gzht_pkg::ST_TRUNC, time_word,
                                 header_bytes);
                    else if (byte_total < gzht_pkg::MIN_STREAM)
                        add_word(gzht_pkg::KIND_TRAILER, gzht_pkg::ST_SHORT, 32'd0, 32'd0);
                    else
                        add_word(gzht_pkg::KIND_TRAILER, gzht_pkg::ST_OK, tail[31:0],
                                 tail[63:32]);
                    phase = gzht_pkg::P_IDLE;
                end
            end

            // last word owed by this byte carries the final flag
            if (due_results.size() > depth_before) begin
                w = due_results[due_results.size() - 1];
                w.final_res = 1'b1;
                due_results[due_results.size() - 1] = w;
            end
            return 1'b1;
        endfunction

        function void check_field(input string fname, input logic [31:0] want,
                                  input logic [31:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0h, got %0h", fname, want, seen);
                mismatches++;
            end
        endfunction

        function void check_word(input gzht_pkg::t_result seen);
            gzht_pkg::t_result want;
            if (due_results.size() == 0) begin
                $error("result word with none owed: kind %0d status %0d",
                       seen.kind, seen.status);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(seen.kind));
            check_field("status", 32'(want.status), 32'(seen.status));
            check_field("flag_bits", 32'(want.flag_bits), 32'(seen.flag_bits));
            check_field("mtime_or_crc", want.mtime_or_crc, seen.mtime_or_crc);
            check_field("extra_flag_byte", 32'(want.extra_flag_byte),
                        32'(seen.extra_flag_byte));
            check_field("os_code", 32'(want.os_code), 32'(seen.os_code));
            check_field("extra_length", 32'(want.extra_length), 32'(seen.extra_length));
            check_field("name_length", 32'(want.name_length), 32'(seen.name_length));
            check_field("comment_length", 32'(want.comment_length),
                        32'(seen.comment_length));
            check_field("length_or_size", want.length_or_size, seen.length_or_size);
            check_field("stream_length", want.stream_length, seen.stream_length);
            check_field("final_res", 32'(want.final_res), 32'(seen.final_res));
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_first_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic        o_kind;
    logic [2:0]  o_status;
    logic [7:0]  o_flag_bits;
    logic [31:0] o_mtime_or_crc;
    logic [7:0]  o_extra_flag_byte;
    logic [7:0]  o_os_code;
    logic [15:0] o_extra_length;
    logic [15:0] o_name_length;
    logic [15:0] o_comment_length;
    logic [31:0] o_length_or_size;
    logic [31:0] o_stream_length;
    logic        o_final_res;
    gzht_pkg::t_result seen_word;

    gzip_parse_tracker tracker = new();

    // Stream under construction: {first, last, byte} per entry
    logic [9:0] stream_q[$];
    int         bytes_parsed;
    bit         tx_idle_on;
    bit         rx_stall_on;

    gzip_header_trailer_parser i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_byte       (i_data_byte),
        .i_first_byte      (i_first_byte),
        .i_last_byte       (i_last_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_status          (o_status),
        .o_flag_bits       (o_flag_bits),
        .o_mtime_or_crc    (o_mtime_or_crc),
        .o_extra_flag_byte (o_extra_flag_byte),
        .o_os_code         (o_os_code),
        .o_extra_length    (o_extra_length),
        .o_name_length     (o_name_length),
        .o_comment_length  (o_comment_length),
        .o_length_or_size  (o_length_or_size),
        .o_stream_length   (o_stream_length),
        .o_final_res       (o_final_res)
    );

    always #5 i_clk = ~i_clk;

    assign seen_word = {o_kind, o_status, o_flag_bits, o_mtime_or_crc, o_extra_flag_byte,
                        o_os_code, o_extra_length, o_name_length, o_comment_length,
                        o_length_or_size, o_stream_length, o_final_res};

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: random stalls, sampled at the rising edge
    initial begin
        int stall_len;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_stall_on && $urandom_range(0, 99) < 25) begin
                stall_len = pick_gap();
                if (stall_len == 0) stall_len = 1;
                i_ready = 1'b0;
                repeat (stall_len - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) tracker.check_word(seen_word);
    end

    // Present one word and hold it until accepted, then maybe idle a while
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_data_byte  = b;
        i_first_byte = first;
        i_last_byte  = last;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        if (tracker.note_byte(b, first, last)) bytes_parsed++;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_stream();
        foreach (stream_q[k]) send_byte(stream_q[k][7:0], stream_q[k][9], stream_q[k][8]);
    endtask

    task automatic add_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), {stream_q.size() == 0, 1'b0, b});
    endtask

    task automatic mark_last();
        stream_q[stream_q.size() - 1][8] = 1'b1;
    endtask

    task automatic cut_to(input int n);
        while (stream_q.size() > n) void'(stream_q.pop_back());
    endtask

    // Well-formed header with random optional fields; returns header length
    task automatic build_header(output int hdr_len);
        logic [7:0]  flg;
        logic [15:0] xl;
        int          n;
        int          r;
        stream_q.delete();
        add_byte(gzht_pkg::ID1_BYTE);
        add_byte(gzht_pkg::ID2_BYTE);
        add_byte(gzht_pkg::CM_DEFLATE);
        flg = 8'($urandom_range(0, 255));
        add_byte(flg);
        repeat (6) add_byte(8'($urandom_range(0, 255)));
        if (flg[gzht_pkg::FLG_FEXTRA]) begin
            r  = $urandom_range(0, 99);
            xl = (r < 20) ? 16'd0 : (r < 90) ? 16'($urandom_range(1, 6))
                 : 16'($urandom_range(7, 40));
            add_byte(xl[7:0]);
            add_byte(xl[15:8]);
            repeat (xl) add_byte(8'($urandom_range(0, 255)));
        end
        if (flg[gzht_pkg::FLG_FNAME]) begin
            n = $urandom_range(0, 6);
            repeat (n) add_byte(8'($urandom_range(1, 255)));
            add_byte(8'd0);
        end
        if (flg[gzht_pkg::FLG_FCMT]) begin
            n = $urandom_range(0, 6);
            repeat (n) add_byte(8'($urandom_range(1, 255)));
            add_byte(8'd0);
        end
        if (flg[gzht_pkg::FLG_FHCRC]) repeat (2) add_byte(8'($urandom_range(0, 255)));
        hdr_len = stream_q.size();
    endtask

    task automatic build_random_stream();
        int         hdr_len;
        int         idx;
        int         r;
        logic [9:0] w;
        r = $urandom_range(0, 99);
        build_header(hdr_len);
        if (r < 70) begin
            // complete stream; short bodies land on both sides of the size floor
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(0, 3))
                add_byte(8'($urandom_range(0, 255)));
            else repeat ($urandom_range(4, 24)) add_byte(8'($urandom_range(0, 255)));
            mark_last();
        end else if (r < 80) begin
            // ends inside the header
            cut_to($urandom_range(1, hdr_len - 1));
            mark_last();
        end else if (r < 87) begin
            // broken magic or method, trailing bytes get dropped
            idx = $urandom_range(0, 2);
            w = stream_q[idx];
            w[7:0] = w[7:0] ^ 8'($urandom_range(1, 255));
            stream_q[idx] = w;
            cut_to(idx + 1 + $urandom_range(0, 4));
            if ($urandom_range(0, 1) == 1) mark_last();
        end else if (r < 93) begin
            // abandoned stream, the next first byte restarts the parse
            cut_to($urandom_range(1, stream_q.size()));
        end else begin
            // noise with random markers
            stream_q.delete();
            repeat ($urandom_range(1, 12))
                stream_q.insert(stream_q.size(),
                                {$urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0,
                                 8'($urandom_range(0, 255))});
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data_byte  = 8'd0;
        i_first_byte = 1'b0;
        i_last_byte  = 1'b0;
        tx_idle_on   = 1'b1;
        rx_stall_on  = 1'b1;
        bytes_parsed = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: dropped byte, bad magic on each id byte, bad method on a last
        // byte, restart mid-header, one-byte stream, short stream whose last byte is its only body byte
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(gzht_pkg::ID1_BYTE, 1'b1, 1'b0);
        send_byte(8'h8A, 1'b0, 1'b0);
        send_byte(gzht_pkg::ID1_BYTE, 1'b1, 1'b0);
        send_byte(gzht_pkg::ID2_BYTE, 1'b0, 1'b0);
        send_byte(8'h09, 1'b0, 1'b1);
        send_byte(gzht_pkg::ID1_BYTE, 1'b1, 1'b0);
        send_byte(gzht_pkg::ID2_BYTE, 1'b0, 1'b0);
        send_byte(gzht_pkg::ID1_BYTE, 1'b1, 1'b1);
        send_byte(gzht_pkg::ID1_BYTE, 1'b1, 1'b0);
        send_byte(gzht_pkg::ID2_BYTE, 1'b0, 1'b0);
        send_byte(gzht_pkg::CM_DEFLATE, 1'b0, 1'b0);
        send_byte(8'hE1, 1'b0, 1'b0);
        repeat (6) send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);

        // random streams, idling switched per stretch
        bytes_parsed = 0;
        tx_idle_on   = 1'b1;
        rx_stall_on  = 1'b1;
        while (bytes_parsed < 1500) begin
            if ($urandom_range(0, 4) == 0) begin
                tx_idle_on  = $urandom_range(0, 3) != 0;
                rx_stall_on = $urandom_range(0, 3) != 0;
            end
            build_random_stream();
            send_stream();
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("gzip_header_trailer_parser regression: pass");
        end else begin
            $display("gzip_header_trailer_parser regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("gzip_header_trailer_parser regression: fail");
        $finish;
    end

endmodule
